// ----- src/histogram_2d_cartesian_top_macros.svh -----
// Assertion macros shared by the histogram RTL.
`ifndef HISTOGRAM_2D_CARTESIAN_TOP_MACROS_SVH
`define HISTOGRAM_2D_CARTESIAN_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define H2C_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The condition must never be true.
`define H2C_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define H2C_ASSERT_IMPLIES(label, ante, cons, msg)
`define H2C_ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ----- src/h2c_pkg.sv -----
// Shared types and constants of the 2D histogram.
`timescale 1ns / 1ps

package h2c_pkg;

    // Operation codes; any code other than count or read-and-clear is a plain read.
    typedef logic [1:0] op_t;
    localparam op_t OP_COUNT      = 2'd0;
    localparam op_t OP_READ_CLEAR = 2'd2;

    // Bin indexes on the channels are six bits wide.
    localparam int BIN_IDX_W = 6;
    typedef logic [BIN_IDX_W-1:0] bin_idx_t;

    // Configuration register indexes.
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t REG_LOW_X  = 3'd0;
    localparam cfg_idx_t REG_HIGH_X = 3'd1;
    localparam cfg_idx_t REG_LOW_Y  = 3'd2;
    localparam cfg_idx_t REG_HIGH_Y = 3'd3;
    localparam cfg_idx_t REG_BINS_X = 3'd4;
    localparam cfg_idx_t REG_BINS_Y = 3'd5;

    localparam int BINS_W = 7;
    typedef logic [BINS_W-1:0] bins_t;
    localparam bins_t BINS_RESET = 7'd64;
    localparam int    MIN_BINS   = 3;

endpackage

// ----- src/h2c_sample_if.sv -----
// Channel that carries sample and read requests into the histogram.
`timescale 1ns / 1ps

interface h2c_sample_if #(
    parameter int SAMPLE_WIDTH = 16
);
    import h2c_pkg::*;

    logic                           valid;
    logic                           ready;
    op_t                            op;
    logic signed [SAMPLE_WIDTH-1:0] sample_x;
    logic signed [SAMPLE_WIDTH-1:0] sample_y;
    bin_idx_t                       read_bin_x;
    bin_idx_t                       read_bin_y;

    modport source (
        output valid, op, sample_x, sample_y, read_bin_x, read_bin_y,
        input  ready
    );

    modport sink (
        input  valid, op, sample_x, sample_y, read_bin_x, read_bin_y,
        output ready
    );
endinterface

// ----- src/h2c_result_if.sv -----
// Channel that carries bin results out of the histogram.
`timescale 1ns / 1ps

interface h2c_result_if #(
    parameter int COUNT_WIDTH = 32
);
    import h2c_pkg::*;

    logic                   valid;
    logic                   ready;
    bin_idx_t               result_bin_x;
    bin_idx_t               result_bin_y;
    logic [COUNT_WIDTH-1:0] bin_count;
    logic                   saturated;

    modport source (
        output valid, result_bin_x, result_bin_y, bin_count, saturated,
        input  ready
    );

    modport sink (
        input  valid, result_bin_x, result_bin_y, bin_count, saturated,
        output ready
    );
endinterface

// ----- src/h2c_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module h2c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- src/h2c_div.sv -----
// Scaling divider: (offset * factor) / span, one quotient bit per cycle.
`timescale 1ns / 1ps

module h2c_div #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int QUOT_WIDTH   = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [SAMPLE_WIDTH-1:0] offset,
    input  logic [QUOT_WIDTH-1:0]   factor,
    input  logic [SAMPLE_WIDTH-1:0] span,
    output logic                    done,
    output logic [QUOT_WIDTH-1:0]   quot
);
    localparam int PW = SAMPLE_WIDTH + QUOT_WIDTH;
    localparam int CW = $clog2(QUOT_WIDTH);

    typedef enum logic [1:0] {
        D_IDLE,
        D_SETUP,
        D_RUN
    } div_state_t;

    div_state_t              state_reg;
    logic [PW-1:0]           prod_reg;
    logic [SAMPLE_WIDTH-1:0] span_reg;
    logic [SAMPLE_WIDTH-1:0] rem_reg;
    logic [QUOT_WIDTH-1:0]   quo_reg;
    logic [CW-1:0]           cnt_reg;
    logic                    done_reg;

    logic [SAMPLE_WIDTH:0]   trial;
    logic [SAMPLE_WIDTH:0]   diff;
    logic                    fits;
    logic                    done_next;

    // The caller guarantees the quotient fits in QUOT_WIDTH bits, so the
    // upper part of the product is already below the span and only the low
    // QUOT_WIDTH bits need restoring steps.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUOT_WIDTH-1]};
        diff      = trial - {1'b0, span_reg};
        fits      = (trial >= {1'b0, span_reg});
        done_next = (state_reg == D_RUN) && (cnt_reg == CW'(QUOT_WIDTH - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            prod_reg  <= '0;
            span_reg  <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        prod_reg  <= PW'(offset) * PW'(factor);
                        span_reg  <= span;
                        state_reg <= D_SETUP;
                    end
                end
                D_SETUP:
                begin
                    rem_reg   <= prod_reg[PW-1:QUOT_WIDTH];
                    quo_reg   <= prod_reg[QUOT_WIDTH-1:0];
                    cnt_reg   <= '0;
                    state_reg <= D_RUN;
                end
                D_RUN:
                begin
                    quo_reg <= {quo_reg[QUOT_WIDTH-2:0], fits};
                    rem_reg <= fits ? diff[SAMPLE_WIDTH-1:0] : trial[SAMPLE_WIDTH-1:0];
                    if (done_next)
                    begin
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule

// ----- src/histogram_2d_cartesian_top.sv -----
// Top level of the 2D histogram with underflow and overflow bins.
// A count passes S_IDLE, S_BIN_X, S_WAIT_X, S_BIN_Y, S_WAIT_Y, S_READ and S_MODIFY; each wait state
// runs the shared divider, and an axis that needs no division skips its wait state.
// A read or read-and-clear passes S_IDLE, S_READ and S_MODIFY. One item is in flight at a time,
// so a new item is taken only once the last result has entered the output register.
// After reset the store is cleared, one entry per cycle, all MAX_BINS_X*MAX_BINS_Y entries (4096).
`timescale 1ns / 1ps
`include "histogram_2d_cartesian_top_macros.svh"

module histogram_2d_cartesian_top #(
    parameter int MAX_BINS_X   = 64,
    parameter int MAX_BINS_Y   = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  h2c_pkg::cfg_idx_t       cfg_index,
    input  logic [SAMPLE_WIDTH-1:0] cfg_data,
    h2c_sample_if.sink              sample_ch,
    h2c_result_if.source            result_ch
);
    import h2c_pkg::*;

    localparam int BWX   = $clog2(MAX_BINS_X);
    localparam int BWY   = $clog2(MAX_BINS_Y);
    localparam int DW    = (BWX > BWY) ? BWX : BWY;
    localparam int NB_W  = DW + 1;
    localparam int DEPTH = MAX_BINS_X * MAX_BINS_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW = AW'(MAX_BINS_Y);
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BIN_X,
        S_WAIT_X,
        S_BIN_Y,
        S_WAIT_Y,
        S_READ,
        S_MODIFY
    } state_t;

    // Configuration registers.
    logic signed [SAMPLE_WIDTH-1:0] low_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] high_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] low_y_reg;
    logic signed [SAMPLE_WIDTH-1:0] high_y_reg;
    bins_t                          bins_x_reg;
    bins_t                          bins_y_reg;

    // Sequencer state and the item in flight.
    state_t                         state_reg;
    logic [AW-1:0]                  clr_addr_reg;
    op_t                            op_reg;
    logic signed [SAMPLE_WIDTH-1:0] sx_reg;
    logic signed [SAMPLE_WIDTH-1:0] sy_reg;
    bin_idx_t                       rbx_reg;
    bin_idx_t                       rby_reg;
    logic [DW-1:0]                  bx_reg;
    logic [DW-1:0]                  by_reg;
    logic                           hit_reg;

    // Output register.
    logic                           out_valid_reg;
    bin_idx_t                       out_bx_reg;
    bin_idx_t                       out_by_reg;
    logic [COUNT_WIDTH-1:0]         out_count_reg;
    logic                           out_sat_reg;

    logic [NB_W-1:0]                nbx;
    logic [NB_W-1:0]                nby;
    logic                           on_y;
    logic signed [SAMPLE_WIDTH-1:0] ax_v;
    logic signed [SAMPLE_WIDTH-1:0] ax_lo;
    logic signed [SAMPLE_WIDTH-1:0] ax_hi;
    logic [NB_W-1:0]                ax_nb;
    logic signed [SAMPLE_WIDTH:0]   ax_off;
    logic signed [SAMPLE_WIDTH:0]   ax_span;
    logic                           ax_below;
    logic                           ax_above;
    logic                           need_div;
    logic [DW-1:0]                  direct_bin;

    logic                           div_start;
    logic                           div_done;
    logic [DW-1:0]                  div_quot;

    logic [AW-1:0]                  addr;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [COUNT_WIDTH-1:0]         ram_wdata;
    logic                           ram_re;
    logic [COUNT_WIDTH-1:0]         ram_rdata;

    logic                           is_count;
    logic                           slot_free;
    logic                           sat;
    logic [COUNT_WIDTH-1:0]         count_next;
    logic                           out_valid_next;

    // Bin counts in use, clamped to the range the store supports.
    always_comb
    begin
        if (bins_x_reg < bins_t'(MIN_BINS))
        begin
            nbx = NB_W'(MIN_BINS);
        end
        else if (32'(bins_x_reg) > MAX_BINS_X)
        begin
            nbx = NB_W'(MAX_BINS_X);
        end
        else
        begin
            nbx = NB_W'(bins_x_reg);
        end

        if (bins_y_reg < bins_t'(MIN_BINS))
        begin
            nby = NB_W'(MIN_BINS);
        end
        else if (32'(bins_y_reg) > MAX_BINS_Y)
        begin
            nby = NB_W'(MAX_BINS_Y);
        end
        else
        begin
            nby = NB_W'(bins_y_reg);
        end
    end

    // One axis is classified at a time; the divider is shared by both.
    always_comb
    begin
        on_y  = (state_reg == S_BIN_Y) || (state_reg == S_WAIT_Y);
        ax_v  = on_y ? sy_reg : sx_reg;
        ax_lo = on_y ? low_y_reg : low_x_reg;
        ax_hi = on_y ? high_y_reg : high_x_reg;
        ax_nb = on_y ? nby : nbx;

        ax_off   = {ax_v[SAMPLE_WIDTH-1], ax_v} - {ax_lo[SAMPLE_WIDTH-1], ax_lo};
        ax_span  = {ax_hi[SAMPLE_WIDTH-1], ax_hi} - {ax_lo[SAMPLE_WIDTH-1], ax_lo};
        ax_below = (ax_v < ax_lo);
        ax_above = (ax_v > ax_hi);
        // A zero-width span sends its single in-range value to overflow.
        need_div = !ax_below && !ax_above && (ax_hi != ax_lo);
        direct_bin = ax_below ? '0 : DW'(ax_nb - NB_W'(1));
    end

    assign div_start = ((state_reg == S_BIN_X) || (state_reg == S_BIN_Y)) && need_div;

    h2c_div #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .QUOT_WIDTH   (DW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .offset (ax_off[SAMPLE_WIDTH-1:0]),
        .factor (DW'(ax_nb - NB_W'(2))),
        .span   (ax_span[SAMPLE_WIDTH-1:0]),
        .done   (div_done),
        .quot   (div_quot)
    );

    // Read-modify-write of the addressed cell.
    always_comb
    begin
        addr       = AW'(bx_reg) * ROW + AW'(by_reg);
        is_count   = (op_reg == OP_COUNT);
        slot_free  = !out_valid_reg || result_ch.ready;
        sat        = is_count && (ram_rdata == '1);
        count_next = sat ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);

        if ((state_reg == S_MODIFY) && slot_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        ram_re = (state_reg == S_READ) && hit_reg;
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = (state_reg == S_MODIFY) && slot_free && hit_reg
                        && (is_count || (op_reg == OP_READ_CLEAR));
            ram_waddr = addr;
            ram_wdata = is_count ? count_next : '0;
        end
    end

    h2c_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg  <= SAMPLE_MIN;
            high_x_reg <= SAMPLE_MAX;
            low_y_reg  <= SAMPLE_MIN;
            high_y_reg <= SAMPLE_MAX;
            bins_x_reg <= BINS_RESET;
            bins_y_reg <= BINS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LOW_X:  low_x_reg  <= cfg_data;
                REG_HIGH_X: high_x_reg <= cfg_data;
                REG_LOW_Y:  low_y_reg  <= cfg_data;
                REG_HIGH_Y: high_y_reg <= cfg_data;
                REG_BINS_X: bins_x_reg <= cfg_data[BINS_W-1:0];
                REG_BINS_Y: bins_y_reg <= cfg_data[BINS_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_COUNT;
            sx_reg        <= '0;
            sy_reg        <= '0;
            rbx_reg       <= '0;
            rby_reg       <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            hit_reg       <= 1'b0;
            out_bx_reg    <= '0;
            out_by_reg    <= '0;
            out_count_reg <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;

            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                S_IDLE:
                begin
                    if (sample_ch.valid)
                    begin
                        op_reg  <= sample_ch.op;
                        sx_reg  <= sample_ch.sample_x;
                        sy_reg  <= sample_ch.sample_y;
                        rbx_reg <= sample_ch.read_bin_x;
                        rby_reg <= sample_ch.read_bin_y;
                        if (sample_ch.op == OP_COUNT)
                        begin
                            hit_reg   <= 1'b1;
                            state_reg <= S_BIN_X;
                        end
                        else
                        begin
                            // Reads outside the store return zero and touch nothing.
                            bx_reg    <= DW'(sample_ch.read_bin_x);
                            by_reg    <= DW'(sample_ch.read_bin_y);
                            hit_reg   <= (32'(sample_ch.read_bin_x) < MAX_BINS_X)
                                         && (32'(sample_ch.read_bin_y) < MAX_BINS_Y);
                            state_reg <= S_READ;
                        end
                    end
                end
                S_BIN_X:
                begin
                    if (need_div)
                    begin
                        state_reg <= S_WAIT_X;
                    end
                    else
                    begin
                        bx_reg    <= direct_bin;
                        state_reg <= S_BIN_Y;
                    end
                end
                S_WAIT_X:
                begin
                    if (div_done)
                    begin
                        bx_reg    <= DW'(div_quot + DW'(1));
                        state_reg <= S_BIN_Y;
                    end
                end
                S_BIN_Y:
                begin
                    if (need_div)
                    begin
                        state_reg <= S_WAIT_Y;
                    end
                    else
                    begin
                        by_reg    <= direct_bin;
                        state_reg <= S_READ;
                    end
                end
                S_WAIT_Y:
                begin
                    if (div_done)
                    begin
                        by_reg    <= DW'(div_quot + DW'(1));
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_MODIFY;
                end
                S_MODIFY:
                begin
                    // Hold here until the output register can take the result.
                    if (slot_free)
                    begin
                        out_bx_reg    <= is_count ? BIN_IDX_W'(bx_reg) : rbx_reg;
                        out_by_reg    <= is_count ? BIN_IDX_W'(by_reg) : rby_reg;
                        out_sat_reg   <= sat;
                        if (is_count)
                        begin
                            out_count_reg <= count_next;
                        end
                        else
                        begin
                            out_count_reg <= hit_reg ? ram_rdata : '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign sample_ch.ready        = (state_reg == S_IDLE);
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.result_bin_x = out_bx_reg;
    assign result_ch.result_bin_y = out_by_reg;
    assign result_ch.bin_count    = out_count_reg;
    assign result_ch.saturated    = out_sat_reg;

    `H2C_ASSERT_IMPLIES(a_sat_at_max, out_valid_reg && out_sat_reg, out_count_reg == '1, "sat")
    `H2C_ASSERT_NEVER(a_no_read_write_overlap, ram_re && ram_we, "store read and written at once")
    `H2C_ASSERT_IMPLIES(a_div_done_waited, div_done, on_y || state_reg == S_WAIT_X, "stray done")
endmodule
